// ----- sv/dfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dfe_pkg;

    localparam int unsigned DEF_FRAME_LIMIT = 1024;

    localparam int unsigned CFG_W      = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
    localparam int unsigned MIN_FRAME  = 4;
    localparam int unsigned LEN_EXTRA  = 4;
    localparam int unsigned SKIP_BIAS  = 3;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned USER_W = 4;

    localparam logic [BYTE_W-1:0] CH_OPEN     = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_CLOSE    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_STATE_LO = 8'h66;
    localparam logic [BYTE_W-1:0] CH_STATE_UP = 8'h46;

    localparam int unsigned U_FIRST = 0;
    localparam int unsigned U_STATE = 1;
    localparam int unsigned U_LENOK = 2;
    localparam int unsigned U_OVF   = 3;

endpackage

`default_nettype wire

// ----- sv/delimited_frame_extractor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream deframer. Bytes are dropped until '<' opens a frame; from then on
// every byte is passed out with first/last marks until '>' closes it. A type
// byte of 'f' or 'F' makes a state frame whose third byte is its length L;
// inside it '>' is data up to offset L-1, and the closing byte carries a
// length check (frame held L+4 bytes). A frame that reaches the configured
// maximum (clamped to 4..FRAME_LIMIT) is cut off with overflow set. One byte
// is taken every cycle unless the output stalls; each result is registered in
// the cycle after its byte, in a single output register that also decides
// input ready. The maximum may be rewritten only while no frame is in flight.
module delimited_frame_extractor #(
    parameter int unsigned FRAME_LIMIT = dfe_pkg::DEF_FRAME_LIMIT
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [dfe_pkg::CFG_W-1:0]      i_cfg_data,     // max_frame_bytes
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [dfe_pkg::BYTE_W-1:0]     s_axis_tdata,   // rx_byte
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [dfe_pkg::BYTE_W-1:0]     m_axis_tdata,   // frame_byte
    output logic                           m_axis_tlast,   // last_of_frame
    output logic [dfe_pkg::USER_W-1:0]     m_axis_tuser    // first_of_frame, state_frame,
                                                           // length_ok, overflow
);
    import dfe_pkg::*;

    localparam int unsigned CNT_W = $clog2(FRAME_LIMIT + 1);
    localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic {PH_HUNT, PH_FRAME} t_phase;

    t_phase                r_phase, n_phase;
    logic [BYTE_W-1:0]     r_skip, n_skip;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_is_state, n_is_state;
    logic [BYTE_W-1:0]     r_decl, n_decl;
    logic [CFG_W-1:0]      r_max;

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;
    logic                  r_out_last;
    logic [USER_W-1:0]     r_out_user;

    logic                  s_fire;
    logic                  n_emit;
    logic                  n_first, n_last, n_lenok, n_ovf;
    logic [CNT_W-1:0]      w_count_inc;
    logic [CMP_W-1:0]      w_limit;
    logic [CMP_W-1:0]      w_need;
    logic [BYTE_W-1:0]     b;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    always_comb begin
        w_limit = CMP_W'(r_max);
        if (w_limit < CMP_W'(MIN_FRAME)) begin
            w_limit = CMP_W'(MIN_FRAME);
        end
        if (w_limit > CMP_W'(FRAME_LIMIT)) begin
            w_limit = CMP_W'(FRAME_LIMIT);
        end
    end

    assign w_count_inc = r_count + CNT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_count    = r_count;
        n_is_state = r_is_state;
        n_decl     = r_decl;
        n_emit     = 1'b0;
        n_first    = 1'b0;
        n_last     = 1'b0;
        n_lenok    = 1'b0;
        n_ovf      = 1'b0;
        w_need     = '0;

        unique case (r_phase)
            PH_HUNT: begin
                if (b == CH_OPEN) begin
                    n_phase    = PH_FRAME;
                    n_count    = CNT_W'(1);
                    n_is_state = 1'b0;
                    n_decl     = '0;
                    n_skip     = '0;
                    n_emit     = 1'b1;
                    n_first    = 1'b1;
                end
            end
            PH_FRAME: begin
                n_emit  = 1'b1;
                n_count = w_count_inc;
                if (r_count == CNT_W'(1)) begin
                    n_is_state = (b == CH_STATE_LO) || (b == CH_STATE_UP);
                    n_last     = (b == CH_CLOSE) && !n_is_state;
                end else if (r_count == CNT_W'(2) && r_is_state) begin
                    n_decl = b;
                    n_skip = (b > BYTE_W'(SKIP_BIAS)) ? b - BYTE_W'(SKIP_BIAS) : '0;
                end else if (r_is_state && r_skip != '0) begin
                    n_skip = r_skip - BYTE_W'(1);
                end else if (b == CH_CLOSE) begin
                    n_last = 1'b1;
                end

                w_need = CMP_W'(n_decl) + CMP_W'(LEN_EXTRA);
                if (n_last) begin
                    n_lenok = n_is_state && (CMP_W'(n_count) == w_need);
                end else if (CMP_W'(n_count) >= w_limit) begin
                    n_last = 1'b1;
                    n_ovf  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_skip      <= '0;
            r_count     <= '0;
            r_is_state  <= 1'b0;
            r_decl      <= '0;
            r_max       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (s_fire) begin
                if (n_last) begin
                    r_phase    <= PH_HUNT;
                    r_skip     <= '0;
                    r_count    <= '0;
                    r_is_state <= 1'b0;
                    r_decl     <= '0;
                end else begin
                    r_phase    <= n_phase;
                    r_skip     <= n_skip;
                    r_count    <= n_count;
                    r_is_state <= n_is_state;
                    r_decl     <= n_decl;
                end
                r_out_valid <= n_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_byte          <= b;
            r_out_last          <= n_last;
            r_out_user[U_FIRST] <= n_first;
            r_out_user[U_STATE] <= n_is_state;
            r_out_user[U_LENOK] <= n_lenok;
            r_out_user[U_OVF]   <= n_ovf;
        end
    end

    a_ovf_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user[U_OVF] |-> r_out_last && !r_out_user[U_LENOK])
        else $error("overflow without frame end");

    a_lenok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user[U_LENOK] |-> r_out_last && r_out_user[U_STATE])
        else $error("length check outside closing state frame byte");

    a_first_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user[U_FIRST] |-> !r_out_user[U_STATE] && !r_out_last)
        else $error("opening byte carries frame-type or end marks");

    a_last_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && n_last |=> r_phase == PH_HUNT && r_count == '0)
        else $error("frame state not cleared after frame end");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FRAME |-> CMP_W'(r_count) < w_limit)
        else $error("frame count reached limit while still in frame");

endmodule

`default_nettype wire
